### rtl/core/diat_pkg.sv
// package for the descriptor id allocator table
// transaction payload types, command and status codes, sequencer states; no dependencies
package diat_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_GET    = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_LOOKUP,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] number_in;
    logic [31:0] handle_in;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  number_out;
    logic [31:0] handle_out;
  } out_item_t;

  localparam out_item_t RES_NOT_FOUND = '{status: ST_NOT_FOUND, number_out: '0, handle_out: '0};
  localparam out_item_t RES_FULL      = '{status: ST_FULL, number_out: '0, handle_out: '0};

endpackage

### rtl/core/diat_ram.sv
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module diat_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/core/descriptor_id_allocator_table_top.sv
// descriptor id allocator table: bitmap allocator of descriptor numbers with a handle store
// depends on diat_pkg and diat_ram
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+------------------------------------------
//  in_     | input     | in_valid/in_stall | in_item_t: cmd, number_in, handle_in
//  out_    | output    | out_valid/out_stall | out_item_t: status, number_out, handle_out
//
// one transaction at a time; in_stall is high while a transaction is in flight
// insert: accepted in idle, then one usage word checked per cycle (read pipelined one
//   word ahead) until a free bit or the last word, then the output register
// remove/get: accept, lookup on the registered ram reads (skipped when out of range), then output
// after reset a clearing pass zeroes the usage ram, one word per cycle, with in_stall high
// a result waits in the output register while out_stall is high
module descriptor_id_allocator_table_top
  import diat_pkg::*;
#(
  parameter int NUM_IDS        = 256,
  parameter int HANDLE_BITS    = 32,
  parameter int SCAN_WORD_BITS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // usage words are a power of two wide so a number splits into word and bit by slicing
  localparam int BIT_W     = $clog2(SCAN_WORD_BITS);
  localparam int WORD_BITS = 1 << BIT_W;
  localparam int NUM_WORDS = (NUM_IDS + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_AW   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int ID_W      = $clog2(NUM_IDS);
  localparam int LAST_BITS = NUM_IDS - (NUM_WORDS - 1) * WORD_BITS;
  localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(NUM_WORDS - 1);
  localparam logic [16:0]        ID_LIMIT  = 17'(NUM_IDS);

  // sequencer and request registers
  state_t              state_r, state_nxt;
  logic [1:0]          req_cmd_r, req_cmd_nxt;
  logic [BIT_W-1:0]    req_bit_r, req_bit_nxt;
  logic [WORD_AW-1:0]  req_word_r, req_word_nxt;
  logic [31:0]         req_handle_r, req_handle_nxt;
  logic [WORD_AW-1:0]  iss_ptr_r, iss_ptr_nxt;   // word being read (also the clear pointer)
  logic [WORD_AW-1:0]  chk_ptr_r, chk_ptr_nxt;   // word whose read data is on map_rd_data
  logic                chk_vld_r, chk_vld_nxt;
  out_item_t           res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;

  // ram ports
  logic                   map_wr_en;
  logic [WORD_AW-1:0]     map_wr_addr;
  logic [WORD_BITS-1:0]   map_wr_data;
  logic [WORD_AW-1:0]     map_rd_addr;
  logic [WORD_BITS-1:0]   map_rd_data;
  logic                   hdl_wr_en;
  logic [ID_W-1:0]        hdl_wr_addr;
  logic [HANDLE_BITS-1:0] hdl_wr_data;
  logic [ID_W-1:0]        hdl_rd_addr;
  logic [HANDLE_BITS-1:0] hdl_rd_data;

  // scan unit: lowest free bit of the checked word
  logic [WORD_BITS-1:0] pad_mask;
  logic [WORD_BITS-1:0] free_vec;
  logic [WORD_BITS-1:0] free_low;
  logic [BIT_W-1:0]     free_bit;
  logic [ID_W-1:0]      found_id;
  logic                 in_range;
  logic [WORD_BITS-1:0] clr_mask;

  diat_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NUM_WORDS)
  ) u_map_ram (
    .clk     (clk),
    .wr_en   (map_wr_en),
    .wr_addr (map_wr_addr),
    .wr_data (map_wr_data),
    .rd_addr (map_rd_addr),
    .rd_data (map_rd_data)
  );

  diat_ram #(
    .WIDTH (HANDLE_BITS),
    .DEPTH (NUM_IDS)
  ) u_handle_ram (
    .clk     (clk),
    .wr_en   (hdl_wr_en),
    .wr_addr (hdl_wr_addr),
    .wr_data (hdl_wr_data),
    .rd_addr (hdl_rd_addr),
    .rd_data (hdl_rd_data)
  );

  // numbers past the capacity in the last word count as used
  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      pad_mask[b] = (chk_ptr_r == LAST_WORD) && (b >= LAST_BITS);
    end
  end

  assign free_vec = ~(map_rd_data | pad_mask);
  // isolate the lowest set bit with one add
  assign free_low = free_vec & (~free_vec + WORD_BITS'(1));

  always_comb begin
    free_bit = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (free_low[b]) begin
        free_bit = free_bit | BIT_W'(b);
      end
    end
  end

  assign found_id = ID_W'({chk_ptr_r, free_bit});
  assign in_range = ({1'b0, in_data.number_in} < ID_LIMIT);
  assign clr_mask = WORD_BITS'(1) << req_bit_r;

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      iss_ptr_r   <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iss_ptr_r   <= iss_ptr_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_cmd_r    <= req_cmd_nxt;
    req_bit_r    <= req_bit_nxt;
    req_word_r   <= req_word_nxt;
    req_handle_r <= req_handle_nxt;
    chk_ptr_r    <= chk_ptr_nxt;
    res_r        <= res_nxt;
    out_data_r   <= out_data_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    req_cmd_nxt    = req_cmd_r;
    req_bit_nxt    = req_bit_r;
    req_word_nxt   = req_word_r;
    req_handle_nxt = req_handle_r;
    iss_ptr_nxt    = iss_ptr_r;
    chk_ptr_nxt    = chk_ptr_r;
    chk_vld_nxt    = chk_vld_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;

    map_wr_en   = 1'b0;
    map_wr_addr = chk_ptr_r;
    map_wr_data = map_rd_data | free_low;
    map_rd_addr = iss_ptr_r;
    hdl_wr_en   = 1'b0;
    hdl_wr_addr = found_id;
    hdl_wr_data = HANDLE_BITS'(req_handle_r);
    hdl_rd_addr = ID_W'(in_data.number_in);

    case (state_r)
      S_CLEAR: begin
        // zero one usage word per cycle
        map_wr_en   = 1'b1;
        map_wr_addr = iss_ptr_r;
        map_wr_data = '0;
        if (iss_ptr_r == LAST_WORD) begin
          iss_ptr_nxt = '0;
          state_nxt   = S_IDLE;
        end else begin
          iss_ptr_nxt = iss_ptr_r + WORD_AW'(1);
        end
      end

      S_IDLE: begin
        // remove/get reads both rams right away
        map_rd_addr = WORD_AW'(in_data.number_in >> BIT_W);
        if (in_valid) begin
          req_cmd_nxt    = in_data.cmd;
          req_bit_nxt    = in_data.number_in[BIT_W-1:0];
          req_word_nxt   = WORD_AW'(in_data.number_in >> BIT_W);
          req_handle_nxt = in_data.handle_in;
          case (in_data.cmd)
            CMD_INSERT: begin
              iss_ptr_nxt = '0;
              chk_vld_nxt = 1'b0;
              state_nxt   = S_SCAN;
            end
            CMD_REMOVE, CMD_GET: begin
              if (in_range) begin
                state_nxt = S_LOOKUP;
              end else begin
                res_nxt   = RES_NOT_FOUND;
                state_nxt = S_RESP;
              end
            end
            default: begin
              res_nxt   = RES_NOT_FOUND;
              state_nxt = S_RESP;
            end
          endcase
        end
      end

      S_SCAN: begin
        // read one word ahead while checking the previous one
        map_rd_addr = iss_ptr_r;
        iss_ptr_nxt = iss_ptr_r + WORD_AW'(1);
        chk_ptr_nxt = iss_ptr_r;
        chk_vld_nxt = 1'b1;
        if (chk_vld_r) begin
          if (|free_vec) begin
            map_wr_en          = 1'b1;
            map_wr_addr        = chk_ptr_r;
            map_wr_data        = map_rd_data | free_low;
            hdl_wr_en          = 1'b1;
            res_nxt.status     = ST_OK;
            res_nxt.number_out = 8'(found_id);
            res_nxt.handle_out = '0;
            state_nxt          = S_RESP;
          end else if (chk_ptr_r == LAST_WORD) begin
            res_nxt   = RES_FULL;
            state_nxt = S_RESP;
          end
        end
      end

      S_LOOKUP: begin
        if (map_rd_data[req_bit_r]) begin
          res_nxt.status     = ST_OK;
          res_nxt.number_out = '0;
          res_nxt.handle_out = 32'(hdl_rd_data);
          if (req_cmd_r == CMD_REMOVE) begin
            map_wr_en   = 1'b1;
            map_wr_addr = req_word_r;
            map_wr_data = map_rd_data & ~clr_mask;
          end
        end else begin
          res_nxt = RES_NOT_FOUND;
        end
        state_nxt = S_RESP;
      end

      S_RESP: begin
        // hand over once the output register is free or being drained
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
